// ----- rtl/core/zgn_pkg.sv -----
// ----------------------------------------------------------------------------
// zgn_pkg - shared types and constants for the zonal gravity pipeline
// Word formats, divider cell state, register indexes and sine coefficients.
// ----------------------------------------------------------------------------
package zgn_pkg;

	// signed working value, wide enough for every product after scaling
	typedef logic signed [63:0] fx_t;

	typedef struct packed {
		logic        [31:0] radius_m;
		logic signed [31:0] latitude_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] gravity_north;
		logic signed [31:0] gravity_down;
	} out_word_t;

	// divider cells: one quotient bit per cell
	localparam int DIV_W  = 32;
	localparam int QW     = 61;
	localparam int X_CELLS = 61;
	localparam int G_CELLS = 41;
	localparam int R_CELLS = 61;

	typedef struct packed {
		logic             flag;   // quotient known to overflow
		logic [DIV_W-1:0] rem;    // partial remainder, below dvs
		logic [DIV_W-1:0] dvs;    // divisor
		logic [QW-1:0]    word;   // numerator bits on top, quotient bits below
	} div_word_t;

	// configuration register indexes
	localparam logic [2:0] REG_ORDER = 3'd0;
	localparam logic [2:0] REG_MU    = 3'd1;
	localparam logic [2:0] REG_REQ   = 3'd2;
	localparam logic [2:0] REG_J2    = 3'd3;
	localparam logic [2:0] REG_J3    = 3'd4;
	localparam logic [2:0] REG_J4    = 3'd5;

	// model orders
	localparam logic [2:0] ORD_OFF   = 3'd0;
	localparam logic [2:0] ORD_POINT = 3'd1;
	localparam logic [2:0] ORD_J2    = 3'd2;
	localparam logic [2:0] ORD_J3    = 3'd3;
	localparam logic [2:0] ORD_J4    = 3'd4;

	localparam fx_t ONE_Q30 = 64'sd1073741824;
	localparam fx_t SAT_LIM = 64'sd1152921504606846976;

	// Horner coefficients of the quarter-wave sine, Q30, highest order first
	localparam int SIN_STEPS = 6;
	localparam logic [30:0] SIN_COEF [SIN_STEPS+1] = '{
		31'd61, 31'd3864, 31'd172272, 31'd5026995, 31'd85569306,
		31'd693598668, 31'd1686629713
	};

endpackage

// ----- rtl/core/zgn_div_cell.sv -----
// ----------------------------------------------------------------------------
// zgn_div_cell - one restoring division step
// Shift one numerator bit into the remainder, subtract when it fits, register.
// ----------------------------------------------------------------------------
module zgn_div_cell (
	input  logic               clk,
	input  zgn_pkg::div_word_t cur,
	output zgn_pkg::div_word_t nxt
);
	import zgn_pkg::*;

	logic [DIV_W:0]   part;
	logic             fits;
	logic [DIV_W-1:0] rem_d;

	always_comb begin
		part  = {cur.rem, cur.word[QW-1]};
		fits  = part >= {1'b0, cur.dvs};
		rem_d = fits ? DIV_W'(part - {1'b0, cur.dvs}) : part[DIV_W-1:0];
	end

	always_ff @(posedge clk) begin
		nxt.flag <= cur.flag;
		nxt.rem  <= rem_d;
		nxt.dvs  <= cur.dvs;
		nxt.word <= {cur.word[QW-2:0], fits};
	end

endmodule

// ----- rtl/core/zgn_mulsh.sv -----
// ----------------------------------------------------------------------------
// zgn_mulsh - pipelined signed multiply, rounded shift and saturation
// Five stages: magnitude, partial products, sum, round and clamp, sign.
// ----------------------------------------------------------------------------
module zgn_mulsh (
	input  logic          clk,
	input  zgn_pkg::fx_t  a,
	input  zgn_pkg::fx_t  b,
	input  logic          k43,   // shift by 43 instead of 30
	output zgn_pkg::fx_t  p
);
	import zgn_pkg::*;

	logic        neg_s1, k_s1;
	logic [63:0] ua_s1, ub_s1;
	logic        neg_s2, k_s2;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic        neg_s3, k_s3;
	logic [127:0] prod_s3;
	logic        neg_s4;
	logic [63:0] q_s4;

	logic [128:0] full;
	logic [128:0] shv;
	logic [63:0]  q_d;

	always_ff @(posedge clk) begin
		neg_s1 <= a[63] ^ b[63];
		ua_s1  <= a[63] ? 64'(-a) : 64'(a);
		ub_s1  <= b[63] ? 64'(-b) : 64'(b);
		k_s1   <= k43;

		neg_s2 <= neg_s1;
		k_s2   <= k_s1;
		p00_s2 <= ua_s1[31:0]  * ub_s1[31:0];
		p01_s2 <= ua_s1[31:0]  * ub_s1[63:32];
		p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
		p11_s2 <= ua_s1[63:32] * ub_s1[63:32];

		neg_s3  <= neg_s2;
		k_s3    <= k_s2;
		prod_s3 <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
			+ {p11_s2, 64'd0};

		neg_s4 <= neg_s3;
		q_s4   <= q_d;

		p <= neg_s4 ? fx_t'(-q_s4) : fx_t'(q_s4);
	end

	// round half away from zero on the magnitude, clamp to 2^60
	always_comb begin
		if (k_s3) begin
			full = {1'b0, prod_s3} + (129'd1 << 42);
			shv  = full >> 43;
		end else begin
			full = {1'b0, prod_s3} + (129'd1 << 29);
			shv  = full >> 30;
		end
		q_d = (shv > 129'(SAT_LIM)) ? 64'(SAT_LIM) : shv[63:0];
	end

endmodule

// ----- rtl/core/zgn_sin_core.sv -----
// ----------------------------------------------------------------------------
// zgn_sin_core - quarter-wave sine polynomial, pipelined Horner chain
// Input t in Q30 (0..2^30), output S(t) in Q30.
// ----------------------------------------------------------------------------
module zgn_sin_core (
	input  logic        clk,
	input  logic [30:0] t,
	output logic [30:0] sin_val
);
	import zgn_pkg::*;

	fx_t u_st   [SIN_STEPS+1];
	fx_t t_st   [SIN_STEPS+1];
	fx_t acc_st [SIN_STEPS+1];
	fx_t tin;
	fx_t u_p;
	fx_t r_p;
	fx_t t_dly_q [5];

	assign tin = fx_t'({33'd0, t});

	zgn_mulsh u_sq (.clk(clk), .a(tin), .b(tin), .k43(1'b0), .p(u_p));

	always_ff @(posedge clk) begin
		t_dly_q[0] <= tin;
		for (int i = 1; i < 5; i++) t_dly_q[i] <= t_dly_q[i-1];
	end

	assign u_st[0]   = u_p;
	assign t_st[0]   = t_dly_q[4];
	assign acc_st[0] = fx_t'({33'd0, SIN_COEF[0]});

	for (genvar g = 0; g < SIN_STEPS; g++) begin : g_step
		fx_t prod;
		fx_t u_dly_q [5];
		fx_t tt_dly_q [5];

		zgn_mulsh u_mul (.clk(clk), .a(acc_st[g]), .b(u_st[g]), .k43(1'b0), .p(prod));

		always_ff @(posedge clk) begin
			u_dly_q[0]  <= u_st[g];
			tt_dly_q[0] <= t_st[g];
			for (int i = 1; i < 5; i++) begin
				u_dly_q[i]  <= u_dly_q[i-1];
				tt_dly_q[i] <= tt_dly_q[i-1];
			end
			acc_st[g+1] <= fx_t'({33'd0, SIN_COEF[g+1]}) - prod;
			u_st[g+1]   <= u_dly_q[4];
			t_st[g+1]   <= tt_dly_q[4];
		end
	end

	zgn_mulsh u_fin (.clk(clk), .a(acc_st[SIN_STEPS]), .b(t_st[SIN_STEPS]), .k43(1'b0),
		.p(r_p));

	// clamp to one
	always_ff @(posedge clk) begin
		sin_val <= (r_p > ONE_Q30) ? 31'(ONE_Q30) : r_p[30:0];
	end

endmodule

// ----- rtl/core/zonal_gravity_ned.sv -----
// ----------------------------------------------------------------------------
// zonal_gravity_ned - zonal harmonic gravity (point mass, J2..J4), north/down
// Fully pipelined: radius and latitude in, Q8.24 north and down gravity out.
// ----------------------------------------------------------------------------
// Usage: the block takes one word in every clock cycle; busy is always low, so
// a word is taken at every edge with start high. Each result appears on result
// for exactly one cycle with done high, in the order the words were taken. The
// receiver cannot stall and none is needed. Each word passes through the divider
// chains: an input register, 61 cells for mu*2^12/R followed by 41 cells for
// the second division by R, the gg clamp register, then the five-stage output
// multiply and the output register. All divisions are rows of one-bit cells
// that register remainder and quotient and hand them to their neighbor; the
// sine/cosine run as Horner chains of pipelined multipliers in parallel.
// Write the configuration registers only while no word is in flight.
// ----------------------------------------------------------------------------
module zonal_gravity_ned (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  zgn_pkg::in_word_t   sample,
	output logic                done,
	output zgn_pkg::out_word_t  result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [51:0]         cfg_data
);
	import zgn_pkg::*;

	localparam int VLD_LEN = 110;
	localparam int R_DLY   = 15;
	localparam int ANG_DLY = 85;
	localparam int ANG_TAP = 37;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	// ---- configuration registers
	logic [2:0]         model_order_q;
	logic [51:0]        mu_q;
	logic [31:0]        req_q;
	logic signed [47:0] j2_q, j3_q, j4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_order_q <= ORD_J4;
			mu_q          <= 52'd398600441800000;
			req_q         <= 32'd6378137;
			j2_q          <= 48'sd1190362000;
			j3_q          <= -48'sd2784700;
			j4_q          <= -48'sd1780800;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ORDER: model_order_q <= cfg_data[2:0];
				REG_MU:    mu_q          <= cfg_data;
				REG_REQ:   req_q         <= cfg_data[31:0];
				REG_J2:    j2_q          <= cfg_data[47:0];
				REG_J3:    j3_q          <= cfg_data[47:0];
				REG_J4:    j4_q          <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	logic [2:0] ord;
	assign ord = (model_order_q > ORD_J4) ? ORD_J4 : model_order_q;

	// Scaled J in Q43; user keeps config static with words in flight, unchecked
	fx_t kp [3];
	fx_t kq [3];
	always_comb begin
		kp[0] = fx_t'(fx_t'(j2_q) * 64'sd12);
		kq[0] = kp[0];
		kp[1] = fx_t'(fx_t'(j3_q) * 64'sd16);
		kq[1] = fx_t'(fx_t'(j3_q) * 64'sd12);
		kp[2] = fx_t'(fx_t'(j4_q) * -64'sd5);
		kq[2] = fx_t'(fx_t'(j4_q) * 64'sd10);
	end

	// ---- accept: the pipeline never stalls
	assign busy = 1'b0;

	logic        vld_q [VLD_LEN];
	logic [31:0] r_s0;
	logic [31:0] ang_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLD_LEN; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start & ~busy;
			for (int i = 1; i < VLD_LEN; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// zero radius counts as one metre
	always_ff @(posedge clk) begin
		r_s0   <= (sample.radius_m == 32'd0) ? 32'd1 : sample.radius_m;
		ang_s0 <= sample.latitude_angle;
	end

	// hold radius and angle until their paths start
	logic [31:0] r_dly_q   [R_DLY];
	logic [31:0] ang_dly_q [ANG_DLY];
	always_ff @(posedge clk) begin
		r_dly_q[0]   <= r_s0;
		ang_dly_q[0] <= ang_s0;
		for (int i = 1; i < R_DLY; i++) r_dly_q[i] <= r_dly_q[i-1];
		for (int i = 1; i < ANG_DLY; i++) ang_dly_q[i] <= ang_dly_q[i-1];
	end

	// ---- gg = mu / R^2 in Q24: x = mu*2^12 / R, then gg = x*2^12 / R
	div_word_t xdiv [X_CELLS+1];
	div_word_t gdiv [G_CELLS+1];
	logic      xsat;
	logic [31:0] ghi;
	logic      gsat;

	// quotient above 2^61 only matters through the gg cap
	always_comb begin
		xsat         = {29'd0, mu_q[51:49]} >= r_s0;
		xdiv[0].flag = xsat;
		xdiv[0].rem  = xsat ? 32'd0 : {29'd0, mu_q[51:49]};
		xdiv[0].dvs  = r_s0;
		xdiv[0].word = {mu_q[48:0], 12'd0};
	end

	for (genvar g = 0; g < X_CELLS; g++) begin : g_xdiv
		zgn_div_cell u_cell (.clk(clk), .cur(xdiv[g]), .nxt(xdiv[g+1]));
	end

	always_comb begin
		ghi          = xdiv[X_CELLS].word[60:29];
		gsat         = xdiv[X_CELLS].flag | (ghi >= xdiv[X_CELLS].dvs);
		gdiv[0].flag = gsat;
		gdiv[0].rem  = gsat ? 32'd0 : ghi;
		gdiv[0].dvs  = xdiv[X_CELLS].dvs;
		gdiv[0].word = {xdiv[X_CELLS].word[28:0], 12'd0, 20'd0};
	end

	for (genvar g = 0; g < G_CELLS; g++) begin : g_gdiv
		zgn_div_cell u_cell (.clk(clk), .cur(gdiv[g]), .nxt(gdiv[g+1]));
	end

	logic [40:0] gg_s103;
	always_ff @(posedge clk) begin
		if (gdiv[G_CELLS].flag || gdiv[G_CELLS].word[40:0] > (41'd1 << 40)) begin
			gg_s103 <= 41'd1 << 40;
		end else begin
			gg_s103 <= gdiv[G_CELLS].word[40:0];
		end
	end

	// ---- rre = Req*2^30 / R, clamped to 2^60
	div_word_t rdiv [R_CELLS+1];
	logic      rsat;
	always_comb begin
		rsat         = {31'd0, req_q[31]} >= r_dly_q[R_DLY-1];
		rdiv[0].flag = rsat;
		rdiv[0].rem  = rsat ? 32'd0 : {31'd0, req_q[31]};
		rdiv[0].dvs  = r_dly_q[R_DLY-1];
		rdiv[0].word = {req_q[30:0], 30'd0};
	end

	for (genvar g = 0; g < R_CELLS; g++) begin : g_rdiv
		zgn_div_cell u_cell (.clk(clk), .cur(rdiv[g]), .nxt(rdiv[g+1]));
	end

	fx_t rq_s77;
	always_ff @(posedge clk) begin
		if (rdiv[R_CELLS].flag || rdiv[R_CELLS].word > 61'(SAT_LIM)) begin
			rq_s77 <= SAT_LIM;
		end else begin
			rq_s77 <= fx_t'({3'd0, rdiv[R_CELLS].word});
		end
	end

	// powers rre^2, rre^3, rre^4
	fx_t rq_dly_q  [10];
	fx_t pw0_dly_q [10];
	fx_t pw1_dly_q [5];
	fx_t pw0_s82, pw1_s87, pw2_s92;

	zgn_mulsh u_pw0 (.clk(clk), .a(rq_s77), .b(rq_s77), .k43(1'b0), .p(pw0_s82));
	zgn_mulsh u_pw1 (.clk(clk), .a(pw0_s82), .b(rq_dly_q[4]), .k43(1'b0), .p(pw1_s87));
	zgn_mulsh u_pw2 (.clk(clk), .a(pw1_s87), .b(rq_dly_q[9]), .k43(1'b0), .p(pw2_s92));

	always_ff @(posedge clk) begin
		rq_dly_q[0]  <= rq_s77;
		pw0_dly_q[0] <= pw0_s82;
		pw1_dly_q[0] <= pw1_s87;
		for (int i = 1; i < 10; i++) begin
			rq_dly_q[i]  <= rq_dly_q[i-1];
			pw0_dly_q[i] <= pw0_dly_q[i-1];
		end
		for (int i = 1; i < 5; i++) pw1_dly_q[i] <= pw1_dly_q[i-1];
	end

	fx_t pw_s92 [3];
	assign pw_s92[0] = pw0_dly_q[9];
	assign pw_s92[1] = pw1_dly_q[4];
	assign pw_s92[2] = pw2_s92;

	// ---- sine and cosine of the latitude
	logic [30:0] t_in, tb_in;
	logic [30:0] sa_s85, sb_s85;
	assign t_in  = {1'b0, ang_dly_q[ANG_TAP][29:0]};
	assign tb_in = 31'(ONE_Q30) - t_in;

	zgn_sin_core u_sin_a (.clk(clk), .t(t_in),  .sin_val(sa_s85));
	zgn_sin_core u_sin_b (.clk(clk), .t(tb_in), .sin_val(sb_s85));

	fx_t sa, sb;
	fx_t s_s86, c_s86;
	assign sa = fx_t'({33'd0, sa_s85});
	assign sb = fx_t'({33'd0, sb_s85});

	// fold the quadrant back in
	always_ff @(posedge clk) begin
		case (ang_dly_q[ANG_DLY-1][31:30])
			QUAD_I:   begin s_s86 <= sa; c_s86 <= sb; end
			QUAD_II:  begin s_s86 <= sb; c_s86 <= -sa; end
			QUAD_III: begin s_s86 <= -sa; c_s86 <= -sb; end
			default:  begin s_s86 <= -sb; c_s86 <= sa; end
		endcase
	end

	// ---- Legendre-type polynomials P and Q
	fx_t s2_s91, c2_s91, cs_s91;
	fx_t s_dly_q [5];
	fx_t c_dly_q [5];
	fx_t s2_dly_q [5];
	fx_t cs_dly_q [5];

	zgn_mulsh u_s2 (.clk(clk), .a(s_s86), .b(s_s86), .k43(1'b0), .p(s2_s91));
	zgn_mulsh u_c2 (.clk(clk), .a(c_s86), .b(c_s86), .k43(1'b0), .p(c2_s91));
	zgn_mulsh u_cs (.clk(clk), .a(c_s86), .b(s_s86), .k43(1'b0), .p(cs_s91));

	always_ff @(posedge clk) begin
		s_dly_q[0]  <= s_s86;
		c_dly_q[0]  <= c_s86;
		s2_dly_q[0] <= s2_s91;
		cs_dly_q[0] <= cs_s91;
		for (int i = 1; i < 5; i++) begin
			s_dly_q[i]  <= s_dly_q[i-1];
			c_dly_q[i]  <= c_dly_q[i-1];
			s2_dly_q[i] <= s2_dly_q[i-1];
			cs_dly_q[i] <= cs_dly_q[i-1];
		end
	end

	fx_t p1_arg, q1_arg, q2_arg, qq0_91;
	fx_t s4_s96, pp1_s96, qq1_s96, qq2_s96;
	always_comb begin
		p1_arg = fx_t'(64'sd3 * ONE_Q30) - fx_t'(64'sd5 * s2_s91);
		q1_arg = fx_t'(64'sd4 * ONE_Q30) - fx_t'(64'sd5 * c2_s91);
		q2_arg = fx_t'(64'sd4 * ONE_Q30) - fx_t'(64'sd7 * c2_s91);
		qq0_91 = fx_t'(cs_s91 <<< 1);
	end

	zgn_mulsh u_s4  (.clk(clk), .a(s2_s91), .b(s2_s91), .k43(1'b0), .p(s4_s96));
	zgn_mulsh u_pp1 (.clk(clk), .a(s_dly_q[4]), .b(p1_arg), .k43(1'b0), .p(pp1_s96));
	zgn_mulsh u_qq1 (.clk(clk), .a(c_dly_q[4]), .b(q1_arg), .k43(1'b0), .p(qq1_s96));
	zgn_mulsh u_qq2 (.clk(clk), .a(qq0_91), .b(q2_arg), .k43(1'b0), .p(qq2_s96));

	fx_t pp_s97 [3];
	fx_t qq_s97 [3];
	always_ff @(posedge clk) begin
		pp_s97[0] <= ONE_Q30 - fx_t'(64'sd3 * s2_dly_q[4]);
		pp_s97[1] <= pp1_s96;
		pp_s97[2] <= fx_t'(64'sd3 * ONE_Q30) - fx_t'(64'sd30 * s2_dly_q[4])
			+ fx_t'(64'sd35 * s4_s96);
		qq_s97[0] <= fx_t'(cs_dly_q[4] <<< 1);
		qq_s97[1] <= qq1_s96;
		qq_s97[2] <= qq2_s96;
	end

	// ---- zonal terms: (J * rre^n) * P and (J * rre^n) * Q in Q30
	fx_t tp1_s97 [3];
	fx_t tq1_s97 [3];
	fx_t tp_s102 [3];
	fx_t tq_s102 [3];

	for (genvar g = 0; g < 3; g++) begin : g_term
		zgn_mulsh u_kp (.clk(clk), .a(kp[g]), .b(pw_s92[g]), .k43(1'b0), .p(tp1_s97[g]));
		zgn_mulsh u_kq (.clk(clk), .a(kq[g]), .b(pw_s92[g]), .k43(1'b0), .p(tq1_s97[g]));
		zgn_mulsh u_tp (.clk(clk), .a(tp1_s97[g]), .b(pp_s97[g]), .k43(1'b1),
			.p(tp_s102[g]));
		zgn_mulsh u_tq (.clk(clk), .a(tq1_s97[g]), .b(qq_s97[g]), .k43(1'b1),
			.p(tq_s102[g]));
	end

	// sum the terms the model order enables; order one keeps the point mass only
	fx_t down_s103, north_s103;
	always_ff @(posedge clk) begin
		down_s103 <= ONE_Q30
			+ ((ord >= ORD_J2) ? tp_s102[0] : 64'sd0)
			+ ((ord >= ORD_J3) ? tp_s102[1] : 64'sd0)
			+ ((ord >= ORD_J4) ? tp_s102[2] : 64'sd0);
		north_s103 <= ((ord >= ORD_J2) ? tq_s102[0] : 64'sd0)
			+ ((ord >= ORD_J3) ? tq_s102[1] : 64'sd0)
			+ ((ord >= ORD_J4) ? tq_s102[2] : 64'sd0);
	end

	// ---- scale by mu/R^2 and saturate to Q8.24; order off gives zero
	fx_t gg_fx;
	fx_t north_s108, down_s108;
	assign gg_fx = fx_t'({23'd0, gg_s103});

	zgn_mulsh u_out_n (.clk(clk), .a(north_s103), .b(gg_fx), .k43(1'b0), .p(north_s108));
	zgn_mulsh u_out_d (.clk(clk), .a(down_s103), .b(gg_fx), .k43(1'b0), .p(down_s108));

	function automatic logic signed [31:0] sat32(input fx_t v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	out_word_t res_q;
	always_ff @(posedge clk) begin
		if (ord == ORD_OFF) begin
			res_q.gravity_north <= 32'sd0;
			res_q.gravity_down  <= 32'sd0;
		end else begin
			res_q.gravity_north <= sat32(north_s108);
			res_q.gravity_down  <= sat32(down_s108);
		end
	end

	assign result = res_q;
	assign done   = vld_q[VLD_LEN-1];

endmodule

// ----- dv/zonal_gravity_ned_test.sv -----
// ----------------------------------------------------------------------------
// zonal_gravity_ned_test - self-checking bench for the zonal gravity pipeline
// Drives radius/latitude words through every model order and several planet
// settings, predicts north/down gravity bit for bit, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zonal_gravity_ned_test;
	import zgn_pkg::*;

	localparam int LATENCY   = 110;
	localparam int CYCLE_CAP = 400000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	in_word_t           sample;
	logic               done;
	out_word_t          result;
	logic               cfg_we;
	logic [2:0]         cfg_idx;
	logic [51:0]        cfg_data;

	zonal_gravity_ned dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// predictor's copy of the configuration
	logic [2:0]          gm_order;
	logic [51:0]         gm_mu;
	logic [31:0]         gm_req;
	logic signed [47:0]  gm_j2, gm_j3, gm_j4;

	in_word_t  pending_words[$];
	out_word_t gravity_due[$];

	int  send_idle_pct;
	int  errors;
	int  words_sent;
	int  words_checked;
	longint cycles;

	// busy as sampled at the accepting edge
	logic busy_seen;

	// exact a*b/2^k, magnitude rounded half away from zero, capped at 2^60
	function automatic longint scaled_mul(longint a, longint b, int k);
		logic          neg;
		logic [127:0]  ua, ub, p;
		logic [63:0]   q;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		p = ua * ub + (128'd1 << (k - 1));
		p = p >> k;
		if (p > 128'(SAT_LIM))
			q = 64'(SAT_LIM);
		else
			q = p[63:0];
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// quarter-wave sine by Horner chain, t in Q30
	function automatic longint quarter_sine(logic [63:0] t);
		logic [63:0] u, acc, r;
		u = (t * t + (64'd1 << 29)) >> 30;
		acc = 64'(SIN_COEF[0]);
		for (int i = 1; i <= SIN_STEPS; i++)
			acc = 64'(SIN_COEF[i]) - ((acc * u + (64'd1 << 29)) >> 30);
		r = (acc * t + (64'd1 << 29)) >> 30;
		if (r > 64'(ONE_Q30))
			r = 64'(ONE_Q30);
		return longint'(r);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic out_word_t predict_gravity(in_word_t w);
		out_word_t   o;
		logic [2:0]  ord;
		logic [63:0] r, ang, t, x, y, rem, gg;
		logic [95:0] ratio;
		longint      down, north, s, c, sa, sb, s2, c2, s4, rq;
		longint      pw[3], kp[3], kq[3], pp[3], qq[3];
		ord = (gm_order > ORD_J4) ? ORD_J4 : gm_order;
		o = '0;
		if (ord == ORD_OFF)
			return o;
		r = 64'(w.radius_m);
		if (r == 0)
			r = 1;
		down = ONE_Q30;
		north = 0;
		if (ord > ORD_POINT) begin
			ang = 64'(unsigned'(w.latitude_angle));
			t = ang & 64'h3fffffff;
			sa = quarter_sine(t);
			sb = quarter_sine(64'(ONE_Q30) - t);
			case (ang[31:30])
				2'd0: begin s = sa; c = sb; end
				2'd1: begin s = sb; c = -sa; end
				2'd2: begin s = -sa; c = -sb; end
				default: begin s = -sb; c = sa; end
			endcase
			s2 = scaled_mul(s, s, 30);
			c2 = scaled_mul(c, c, 30);
			s4 = scaled_mul(s2, s2, 30);
			pp[0] = ONE_Q30 - 3 * s2;
			qq[0] = 2 * scaled_mul(c, s, 30);
			pp[1] = scaled_mul(s, 3 * ONE_Q30 - 5 * s2, 30);
			qq[1] = scaled_mul(c, 4 * ONE_Q30 - 5 * c2, 30);
			pp[2] = 3 * ONE_Q30 - 30 * s2 + 35 * s4;
			qq[2] = scaled_mul(qq[0], 4 * ONE_Q30 - 7 * c2, 30);
			kp[0] = 12 * longint'(gm_j2); kq[0] = 12 * longint'(gm_j2);
			kp[1] = 16 * longint'(gm_j3); kq[1] = 12 * longint'(gm_j3);
			kp[2] = -5 * longint'(gm_j4); kq[2] = 10 * longint'(gm_j4);
			ratio = (96'(gm_req) << 30) / 96'(r);
			rq = (ratio > 96'(SAT_LIM)) ? SAT_LIM : longint'(ratio[63:0]);
			pw[0] = scaled_mul(rq, rq, 30);
			pw[1] = scaled_mul(pw[0], rq, 30);
			pw[2] = scaled_mul(pw[1], rq, 30);
			for (int n = 0; n + 1 < ord; n++) begin
				down += scaled_mul(scaled_mul(kp[n], pw[n], 30), pp[n], 43);
				north += scaled_mul(scaled_mul(kq[n], pw[n], 30), qq[n], 43);
			end
		end
		x = (64'(gm_mu) << 12) / r;
		y = x / r;
		rem = x % r;
		if (y >= (64'd1 << 28))
			gg = 64'd1 << 40;
		else begin
			gg = (y << 12) + ((rem << 12) / r);
			if (gg > (64'd1 << 40))
				gg = 64'd1 << 40;
		end
		o.gravity_north = clamp32(scaled_mul(north, longint'(gg), 30));
		o.gravity_down = clamp32(scaled_mul(down, longint'(gg), 30));
		return o;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// driver: offer the head word at the falling edge, drop it once taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy_seen) begin
				gravity_due.push_back(predict_gravity(sample));
				void'(pending_words.pop_front());
				words_sent++;
			end
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				sample <= pending_words[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		busy_seen <= busy;

	// monitor: compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && done) begin
			if (gravity_due.size() == 0) begin
				$error("unexpected result word north=%0d down=%0d",
					result.gravity_north, result.gravity_down);
				errors++;
			end else begin
				exp_w = gravity_due.pop_front();
				if (result.gravity_north !== exp_w.gravity_north) begin
					$error("gravity_north expected %0d got %0d",
						exp_w.gravity_north, result.gravity_north);
					errors++;
				end
				if (result.gravity_down !== exp_w.gravity_down) begin
					$error("gravity_down expected %0d got %0d",
						exp_w.gravity_down, result.gravity_down);
					errors++;
				end
				words_checked++;
			end
		end
	end

	// write one register at a falling edge, mirror it in the predictor
	task automatic write_reg(logic [2:0] idx, logic [51:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_ORDER: gm_order = val[2:0];
			REG_MU:    gm_mu = val;
			REG_REQ:   gm_req = val[31:0];
			REG_J2:    gm_j2 = val[47:0];
			REG_J3:    gm_j3 = val[47:0];
			REG_J4:    gm_j4 = val[47:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every queued word is in and every result is out
	task automatic drain();
		while (pending_words.size() > 0 || gravity_due.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic in_word_t rand_word(bit wide);
		in_word_t w;
		case ($urandom_range(7))
			0: w.radius_m = $urandom_range(1, 100);
			1: w.radius_m = $urandom;
			2: w.radius_m = 32'hffffffff - $urandom_range(0, 3);
			default: w.radius_m = 6300000 + $urandom_range(0, 40000000);
		endcase
		if (wide || $urandom_range(9) == 0)
			w.latitude_angle = $urandom;
		else
			w.latitude_angle = $signed($urandom_range(0, 32'h80000000)) - 32'sh40000000;
		return w;
	endfunction

	task automatic random_phase(int count, int idle);
		send_idle_pct = idle;
		for (int i = 0; i < count; i++)
			pending_words.push_back(rand_word($urandom_range(3) == 0));
		drain();
	endtask

	// planet settings cycled through the random phases
	task automatic planet_setting(int which);
		case (which)
			0: begin
				write_reg(REG_MU, 52'd398600441800000);
				write_reg(REG_REQ, 32'd6378137);
				write_reg(REG_J2, 52'(48'sd1190362000));
				write_reg(REG_J3, 52'(-48'sd2784700));
				write_reg(REG_J4, 52'(-48'sd1780800));
			end
			1: begin
				// extremes of every register
				write_reg(REG_MU, 52'hfffffffffffff);
				write_reg(REG_REQ, 32'hffffffff);
				write_reg(REG_J2, 52'(48'sh7fffffffffff));
				write_reg(REG_J3, 52'(48'sh800000000000));
				write_reg(REG_J4, 52'(48'sh7fffffffffff));
			end
			2: begin
				write_reg(REG_MU, 52'd1);
				write_reg(REG_REQ, 32'd0);
				write_reg(REG_J2, 52'(48'sh800000000000));
				write_reg(REG_J3, 52'(48'sh7fffffffffff));
				write_reg(REG_J4, 52'(48'sh800000000000));
			end
			default: begin
				write_reg(REG_MU, 52'({$urandom, $urandom}));
				write_reg(REG_REQ, $urandom);
				write_reg(REG_J2, 52'({$urandom, $urandom} & 64'hffffffffffff));
				write_reg(REG_J3, 52'($signed($urandom_range(0, 20000000)) - 10000000));
				write_reg(REG_J4, 52'($signed($urandom_range(0, 20000000)) - 10000000));
			end
		endcase
	endtask

	initial begin
		in_word_t w;
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_ORDER;
		cfg_data = '0;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		cycles = 0;
		send_idle_pct = 0;
		gm_order = ORD_J4;
		gm_mu = 52'd398600441800000;
		gm_req = 32'd6378137;
		gm_j2 = 48'sd1190362000;
		gm_j3 = -48'sd2784700;
		gm_j4 = -48'sd1780800;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, poles, equator, wrapped latitudes, zero radius
		send_idle_pct = 20;
		w.radius_m = 0; w.latitude_angle = 0; pending_words.push_back(w);
		w.radius_m = 1; w.latitude_angle = 32'sh40000000; pending_words.push_back(w);
		w.radius_m = 32'hffffffff; w.latitude_angle = -32'sh40000000;
		pending_words.push_back(w);
		w.radius_m = 6378137; w.latitude_angle = 32'sh7fffffff; pending_words.push_back(w);
		w.radius_m = 6378137; w.latitude_angle = 32'sh80000000; pending_words.push_back(w);
		w.radius_m = 6378137; w.latitude_angle = 32'sh20000000; pending_words.push_back(w);
		w.radius_m = 7000000; w.latitude_angle = 32'shc0000001; pending_words.push_back(w);
		w.radius_m = 3; w.latitude_angle = 32'sh3fffffff; pending_words.push_back(w);
		drain();
		// every order, including those above four
		for (int o = 0; o < 8; o++) begin
			write_reg(REG_ORDER, 3'(o));
			w.radius_m = 6378137 + 1000 * o; w.latitude_angle = 32'sh15555555;
			pending_words.push_back(w);
			w.radius_m = 1; w.latitude_angle = -32'sh2aaaaaaa;
			pending_words.push_back(w);
			drain();
		end
		write_reg(REG_MU, 52'd0);
		write_reg(REG_ORDER, ORD_J4);
		w.radius_m = 6378137; w.latitude_angle = 32'sh10000000;
		pending_words.push_back(w);
		drain();

		// random: sender idle rate per group of four phases, each phase with its own order and planet setting
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_ORDER, (ph % 4 == 3) ? 3'($urandom_range(7)) : ORD_J4 - 3'(ph % 3));
			planet_setting(ph % 4);
			random_phase(66, (ph < 4) ? 36 : (ph < 8) ? 77 : 0);
		end

		repeat (LATENCY) @(posedge clk);
		$display("covered %0d words over orders 0..7 and %0d planet settings; %0d checked",
			words_sent, 4, words_checked);
		if (errors == 0 && gravity_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- zonal_gravity_ned.f -----
rtl/core/zgn_pkg.sv
rtl/core/zgn_div_cell.sv
rtl/core/zgn_mulsh.sv
rtl/core/zgn_sin_core.sv
rtl/core/zonal_gravity_ned.sv
dv/zonal_gravity_ned_test.sv
